// ===== design/rpn_float_stack_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// RPN float stack evaluator assertion macros
// Shared assertion forms for the evaluator modules. They compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RPN_FLOAT_STACK_EVALUATOR_DEFINES_SVH
`define RPN_FLOAT_STACK_EVALUATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RFE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define RFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RFE_ASSERT_IMPL(label, ante, cons)
`define RFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/rfe_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN float stack evaluator package
// Opcodes, error codes, defaults and the control bundle of the float unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

   localparam int STACK_DEPTH_DEF = 16;

   typedef logic [2:0] opcode_type;
   typedef logic [1:0] err_type;

   localparam opcode_type OP_PUSH   = 3'd0;
   localparam opcode_type OP_ADD    = 3'd1;
   localparam opcode_type OP_SUB    = 3'd2;
   localparam opcode_type OP_MUL    = 3'd3;
   localparam opcode_type OP_DIV    = 3'd4;
   localparam opcode_type OP_SQUARE = 3'd5;
   localparam opcode_type OP_SQRT   = 3'd6;

   localparam err_type ERR_NONE     = 2'd0;
   localparam err_type ERR_DIV_ZERO = 2'd1;
   localparam err_type ERR_NEG_ROOT = 2'd2;
   localparam err_type ERR_SYNTAX   = 2'd3;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   typedef struct packed {
      logic       start;
      opcode_type op;
   } fpu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fpu_rsp_type;

endpackage

`default_nettype wire

// ===== design/rfe_if.sv =====
// ----------------------------------------------------------------------------
// RPN float stack evaluator channels
// Valid/ready channels for tokens and for expression results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfe_req_if;
   logic                valid;
   logic                ready;
   rfe_pkg::opcode_type opcode;
   logic [31:0]         number_bits;
   logic                last_token;

   modport source (output valid, output opcode, output number_bits, output last_token,
                   input ready);
   modport sink   (input valid, input opcode, input number_bits, input last_token,
                   output ready);
endinterface

interface rfe_rsp_if;
   logic             valid;
   logic             ready;
   logic [31:0]      result_bits;
   rfe_pkg::err_type error_code;

   modport source (output valid, output result_bits, output error_code, input ready);
   modport sink   (input valid, input result_bits, input error_code, output ready);
endinterface

`default_nettype wire

// ===== design/rfe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/rfe_fpu.sv =====
// ----------------------------------------------------------------------------
// RPN float stack evaluator float unit
// Iterative single-precision add, subtract, multiply, divide, square and
// square root with round to nearest even and a canonical NaN.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rpn_float_stack_evaluator_defines.svh"

module rfe_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  rfe_pkg::fpu_req_type ctrl,
   input  logic [31:0]          a_bits,
   input  logic [31:0]          b_bits,
   output rfe_pkg::fpu_rsp_type stat,
   output logic [31:0]          result_bits
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NORMIN = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_ITER   = 3'd3;
   localparam logic [2:0] S_NORM   = 3'd4;
   localparam logic [2:0] S_DENORM = 3'd5;
   localparam logic [2:0] S_ROUND  = 3'd6;

   logic [2:0]          state_ff, state_in;
   rfe_pkg::opcode_type op_ff, op_in;
   logic                sa_ff, sa_in, sb_ff, sb_in;
   logic [23:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic signed [10:0]  ea_ff, ea_in, eb_ff, eb_in;
   logic [27:0]         sig_ff, sig_in;
   logic                stk_ff, stk_in;
   logic signed [10:0]  e_ff, e_in;
   logic                rs_ff, rs_in;
   logic [31:0]         res_ff, res_in;
   logic                done_ff, done_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [30:0]         rem_ff, rem_in;
   logic [55:0]         rad_ff, rad_in;
   logic [27:0]         root_ff, root_in;

   // Operand decode for the start cycle.
   logic [7:0]  ax, bx;
   logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   logic        sbe, sx;
   logic        spec;
   logic [31:0] spec_val;

   assign ax     = a_bits[30:23];
   assign bx     = b_bits[30:23];
   assign a_nan  = (ax == 8'hFF) && (a_bits[22:0] != 23'd0);
   assign a_inf  = (ax == 8'hFF) && (a_bits[22:0] == 23'd0);
   assign a_zero = (a_bits[30:0] == 31'd0);
   assign b_nan  = (bx == 8'hFF) && (b_bits[22:0] != 23'd0);
   assign b_inf  = (bx == 8'hFF) && (b_bits[22:0] == 23'd0);
   assign b_zero = (b_bits[30:0] == 31'd0);
   assign sbe    = b_bits[31] ^ (ctrl.op == rfe_pkg::OP_SUB);
   assign sx     = a_bits[31] ^ b_bits[31];

   always_comb begin
      spec     = 1'b1;
      spec_val = a_bits;
      case (ctrl.op)
         rfe_pkg::OP_ADD, rfe_pkg::OP_SUB: begin
            if (a_nan || b_nan || (a_inf && b_inf && (a_bits[31] != sbe))) begin
               spec_val = rfe_pkg::CANON_NAN;
            end else if (a_inf) begin
               spec_val = a_bits;
            end else if (b_inf) begin
               spec_val = {sbe, b_bits[30:0]};
            end else if (a_zero && b_zero) begin
               spec_val = {a_bits[31] & sbe, 31'd0};
            end else if (a_zero) begin
               spec_val = {sbe, b_bits[30:0]};
            end else if (b_zero) begin
               spec_val = a_bits;
            end else begin
               spec = 1'b0;
            end
         end
         rfe_pkg::OP_MUL, rfe_pkg::OP_SQUARE: begin
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               spec_val = rfe_pkg::CANON_NAN;
            end else if (a_inf || b_inf) begin
               spec_val = {sx, 8'hFF, 23'd0};
            end else if (a_zero || b_zero) begin
               spec_val = {sx, 31'd0};
            end else begin
               spec = 1'b0;
            end
         end
         rfe_pkg::OP_DIV: begin
            if (a_nan || b_nan || (a_inf && b_inf)) begin
               spec_val = rfe_pkg::CANON_NAN;
            end else if (a_inf || b_zero) begin
               spec_val = {sx, 8'hFF, 23'd0};
            end else if (b_inf || a_zero) begin
               spec_val = {sx, 31'd0};
            end else begin
               spec = 1'b0;
            end
         end
         rfe_pkg::OP_SQRT: begin
            if (a_nan) begin
               spec_val = rfe_pkg::CANON_NAN;
            end else if (a_zero || a_inf) begin
               spec_val = a_bits;
            end else begin
               spec = 1'b0;
            end
         end
         default: begin
            spec = 1'b1;
         end
      endcase
   end

   // Alignment adder.
   logic               a_big;
   logic signed [10:0] e_big, e_sml, d_full;
   logic [23:0]        m_big, m_sml;
   logic               s_big, s_sml;
   logic [27:0]        ext_big, ext_sml, al, add_sum;

   always_comb begin
      a_big   = (ea_ff > eb_ff) || ((ea_ff == eb_ff) && (ma_ff >= mb_ff));
      e_big   = a_big ? ea_ff : eb_ff;
      e_sml   = a_big ? eb_ff : ea_ff;
      m_big   = a_big ? ma_ff : mb_ff;
      m_sml   = a_big ? mb_ff : ma_ff;
      s_big   = a_big ? sa_ff : sb_ff;
      s_sml   = a_big ? sb_ff : sa_ff;
      d_full  = e_big - e_sml;
      ext_big = {1'b0, m_big, 3'b000};
      ext_sml = {1'b0, m_sml, 3'b000};
      if (d_full > 11'sd27) begin
         al = 28'd1;
      end else begin
         al = (ext_sml >> d_full[4:0])
            | {27'd0, |(ext_sml & ((28'd1 << d_full[4:0]) - 28'd1))};
      end
      add_sum = (s_big == s_sml) ? (ext_big + al) : (ext_big - al);
   end

   // Multiplier, registered into the significand register.
   logic [47:0] prod;
   assign prod = ma_ff * mb_ff;

   // One restoring divide step and one square root step.
   logic [25:0] div_diff;
   logic        div_bit;
   logic [24:0] div_rem;
   logic [30:0] sq_rem2, sq_trial, sq_rem;
   logic        sq_bit;

   always_comb begin
      div_diff = {1'b0, rem_ff[24:0]} - {2'b00, mb_ff};
      div_bit  = !div_diff[25];
      div_rem  = div_bit ? div_diff[24:0] : rem_ff[24:0];
      sq_rem2  = {rem_ff[28:0], rad_ff[55:54]};
      sq_trial = {1'b0, root_ff[27:0], 2'b01};
      sq_bit   = (sq_rem2 >= sq_trial);
      sq_rem   = sq_bit ? (sq_rem2 - sq_trial) : sq_rem2;
   end

   // Rounding and packing.
   logic [23:0]        mant, mant_f;
   logic               g_bit, st_bit, inc;
   logic [24:0]        m25;
   logic signed [10:0] e_f, biased;
   logic [31:0]        rnd;

   always_comb begin
      mant   = sig_ff[27:4];
      g_bit  = sig_ff[3];
      st_bit = (|sig_ff[2:0]) | stk_ff;
      inc    = g_bit & (st_bit | mant[0]);
      m25    = {1'b0, mant} + {24'd0, inc};
      if (m25[24]) begin
         mant_f = m25[24:1];
         e_f    = e_ff + 11'sd1;
      end else begin
         mant_f = m25[23:0];
         e_f    = e_ff;
      end
      biased = e_f + 11'sd127;
      if (biased >= 11'sd255) begin
         rnd = {rs_ff, 8'hFF, 23'd0};
      end else begin
         rnd = {rs_ff, (mant_f[23] ? biased[7:0] : 8'd0), mant_f[22:0]};
      end
   end

   logic [24:0]        sq_m2;
   logic signed [10:0] sq_e2;

   assign sq_m2 = ea_ff[0] ? {ma_ff, 1'b0} : {1'b0, ma_ff};
   assign sq_e2 = ea_ff[0] ? (ea_ff - 11'sd1) : ea_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      sig_in   = sig_ff;
      stk_in   = stk_ff;
      e_in     = e_ff;
      rs_in    = rs_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               op_in = ctrl.op;
               sa_in = a_bits[31];
               sb_in = sbe;
               ma_in = {ax != 8'd0, a_bits[22:0]};
               mb_in = {bx != 8'd0, b_bits[22:0]};
               ea_in = (ax == 8'd0) ? -11'sd126 : ($signed({3'b000, ax}) - 11'sd127);
               eb_in = (bx == 8'd0) ? -11'sd126 : ($signed({3'b000, bx}) - 11'sd127);
               if (spec) begin
                  res_in  = spec_val;
                  done_in = 1'b1;
               end else begin
                  state_in = S_NORMIN;
               end
            end
         end
         S_NORMIN: begin
            // Subnormal operands are brought to a leading one, one bit a cycle.
            if (!ma_ff[23]) begin
               ma_in = {ma_ff[22:0], 1'b0};
               ea_in = ea_ff - 11'sd1;
            end
            if (!mb_ff[23]) begin
               mb_in = {mb_ff[22:0], 1'b0};
               eb_in = eb_ff - 11'sd1;
            end
            if (ma_ff[23] && mb_ff[23]) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            stk_in = 1'b0;
            case (op_ff)
               rfe_pkg::OP_ADD, rfe_pkg::OP_SUB: begin
                  sig_in   = add_sum;
                  e_in     = e_big + 11'sd1;
                  rs_in    = s_big;
                  state_in = S_NORM;
               end
               rfe_pkg::OP_MUL, rfe_pkg::OP_SQUARE: begin
                  sig_in   = prod[47:20];
                  stk_in   = |prod[19:0];
                  e_in     = ea_ff + eb_ff + 11'sd1;
                  rs_in    = sa_ff ^ sb_ff;
                  state_in = S_NORM;
               end
               rfe_pkg::OP_DIV: begin
                  rem_in   = {7'd0, ma_ff};
                  root_in  = '0;
                  cnt_in   = 5'd27;
                  e_in     = ea_ff - eb_ff;
                  rs_in    = sa_ff ^ sb_ff;
                  state_in = S_ITER;
               end
               default: begin
                  // Square root: the radicand is scaled so that the root has 28 bits.
                  rad_in   = {sq_m2, 31'd0};
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = 5'd27;
                  e_in     = sq_e2 >>> 1;
                  rs_in    = 1'b0;
                  state_in = S_ITER;
               end
            endcase
         end
         S_ITER: begin
            cnt_in = cnt_ff - 5'd1;
            if (op_ff == rfe_pkg::OP_DIV) begin
               root_in = {root_ff[26:0], div_bit};
               rem_in  = {6'd0, div_rem[23:0], 1'b0};
               if (cnt_ff == 5'd0) begin
                  sig_in   = {root_ff[26:0], div_bit};
                  stk_in   = (div_rem != 25'd0);
                  state_in = S_NORM;
               end
            end else begin
               root_in = {root_ff[26:0], sq_bit};
               rem_in  = sq_rem;
               rad_in  = {rad_ff[53:0], 2'b00};
               if (cnt_ff == 5'd0) begin
                  sig_in   = {root_ff[26:0], sq_bit};
                  stk_in   = (sq_rem != 31'd0);
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            if (sig_ff == 28'd0) begin
               // Exact cancellation gives positive zero.
               res_in   = 32'd0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (!sig_ff[27]) begin
               sig_in = {sig_ff[26:0], 1'b0};
               e_in   = e_ff - 11'sd1;
            end else begin
               state_in = S_DENORM;
            end
         end
         S_DENORM: begin
            if (e_ff < -11'sd160) begin
               // Far below the subnormal range everything folds into the sticky bit.
               stk_in = stk_ff | (|sig_ff);
               sig_in = '0;
               e_in   = -11'sd126;
            end else if (e_ff < -11'sd126) begin
               stk_in = stk_ff | sig_ff[0];
               sig_in = {1'b0, sig_ff[27:1]};
               e_in   = e_ff + 11'sd1;
            end else begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            res_in   = rnd;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      sig_ff  <= sig_in;
      stk_ff  <= stk_in;
      e_ff    <= e_in;
      rs_ff   <= rs_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign stat.busy   = (state_ff != S_IDLE);
   assign stat.done   = done_ff;
   assign result_bits = res_ff;

   `RFE_ASSERT_IMPL(a_done_in_idle, done_ff, state_ff == S_IDLE)
   `RFE_ASSERT_IMPL(a_round_normalized, state_ff == S_ROUND,
                    sig_ff[27] || (e_ff == -11'sd126))
   `RFE_ASSERT_NEXT(a_normin_exit, state_ff == S_NORMIN,
                    state_ff == S_NORMIN || state_ff == S_EXEC)

endmodule

`default_nettype wire

// ===== design/rpn_float_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// RPN float stack evaluator
// Evaluates postfix tokens on single-precision floats over an operand stack
// and returns the value and error code of each expression.
// ----------------------------------------------------------------------------
//   Channel    Direction  Carries
//   req_chan   in         opcode, number_bits, last_token
//   rsp_chan   out        result_bits, error_code (one per last token)
//
// A push or an ignored token goes from the idle state to the finish state; an
// operator reads its operands from the stack, is checked, and then runs on the
// iterative float unit, which finds quotient and root bits one per cycle and
// shifts one bit per cycle to normalize subnormal operands and cancelled sums
// and to denormalize tiny results. A last token also passes the response state.
// Reset is synchronous; the stack needs no clearing pass. A stalled result
// blocks only the next last token.
`default_nettype none
`include "rpn_float_stack_evaluator_defines.svh"

module rpn_float_stack_evaluator #(
   parameter int STACK_DEPTH = rfe_pkg::STACK_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   rfe_req_if.sink   req_chan,
   rfe_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   localparam logic [3:0] T_IDLE    = 4'd0;
   localparam logic [3:0] T_RD_TOP  = 4'd1;
   localparam logic [3:0] T_RD_SEC  = 4'd2;
   localparam logic [3:0] T_CHECK   = 4'd3;
   localparam logic [3:0] T_FPU     = 4'd4;
   localparam logic [3:0] T_FINISH  = 4'd5;
   localparam logic [3:0] T_RD_ZERO = 4'd6;
   localparam logic [3:0] T_RESP    = 4'd7;

   function automatic logic is_binary(input rfe_pkg::opcode_type op);
      return (op == rfe_pkg::OP_ADD) || (op == rfe_pkg::OP_SUB) ||
             (op == rfe_pkg::OP_MUL) || (op == rfe_pkg::OP_DIV);
   endfunction

   logic [3:0]          state_ff, state_in;
   logic [DW-1:0]       depth_ff, depth_in;
   rfe_pkg::err_type    err_ff, err_in;
   rfe_pkg::opcode_type op_ff, op_in;
   logic                last_ff, last_in;
   logic [31:0]         top_ff, top_in, sec_ff, sec_in;
   logic [31:0]         value_ff, value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_result_ff, rsp_result_in;
   rfe_pkg::err_type    rsp_err_ff, rsp_err_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;
   logic [DW-1:0] dm1, dm2;

   rfe_pkg::fpu_req_type fpu_req;
   rfe_pkg::fpu_rsp_type fpu_rsp;
   logic [31:0]          fpu_result;

   assign dm1 = depth_ff - DW'(1);
   assign dm2 = depth_ff - DW'(2);

   rfe_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rfe_fpu u_fpu (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (fpu_req),
      .a_bits      (is_binary(op_ff) ? sec_ff : top_ff),
      .b_bits      (top_ff),
      .stat        (fpu_rsp),
      .result_bits (fpu_result)
   );

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      top_in        = top_ff;
      sec_in        = sec_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in = rsp_result_ff;
      rsp_err_in    = rsp_err_ff;
      ram_we        = 1'b0;
      ram_waddr     = depth_ff[AW-1:0];
      ram_wdata     = req_chan.number_bits;
      ram_raddr     = dm1[AW-1:0];
      fpu_req.start = 1'b0;
      fpu_req.op    = op_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.opcode;
               last_in  = req_chan.last_token;
               state_in = T_FINISH;
               // Once an error is latched, tokens are skipped until the last one.
               if (err_ff == rfe_pkg::ERR_NONE) begin
                  if (req_chan.opcode == rfe_pkg::OP_PUSH) begin
                     if (depth_ff == DW'(STACK_DEPTH)) begin
                        err_in = rfe_pkg::ERR_SYNTAX;
                     end else begin
                        ram_we   = 1'b1;
                        depth_in = depth_ff + DW'(1);
                     end
                  end else if (is_binary(req_chan.opcode)) begin
                     if (depth_ff < DW'(2)) begin
                        err_in = rfe_pkg::ERR_SYNTAX;
                     end else begin
                        state_in = T_RD_TOP;
                     end
                  end else if ((req_chan.opcode == rfe_pkg::OP_SQUARE) ||
                               (req_chan.opcode == rfe_pkg::OP_SQRT)) begin
                     if (depth_ff == '0) begin
                        err_in = rfe_pkg::ERR_SYNTAX;
                     end else begin
                        state_in = T_RD_TOP;
                     end
                  end
               end
            end
         end
         T_RD_TOP: begin
            top_in = ram_rdata;
            if (is_binary(op_ff)) begin
               ram_raddr = dm2[AW-1:0];
               state_in  = T_RD_SEC;
            end else begin
               state_in = T_CHECK;
            end
         end
         T_RD_SEC: begin
            sec_in   = ram_rdata;
            state_in = T_CHECK;
         end
         T_CHECK: begin
            if ((op_ff == rfe_pkg::OP_DIV) && (top_ff[30:0] == 31'd0)) begin
               err_in   = rfe_pkg::ERR_DIV_ZERO;
               state_in = T_FINISH;
            end else if ((op_ff == rfe_pkg::OP_SQRT) && top_ff[31] &&
                         (top_ff[30:0] != 31'd0) && (top_ff[30:0] <= 31'h7F80_0000)) begin
               err_in   = rfe_pkg::ERR_NEG_ROOT;
               state_in = T_FINISH;
            end else begin
               fpu_req.start = 1'b1;
               state_in      = T_FPU;
            end
         end
         T_FPU: begin
            if (fpu_rsp.done) begin
               ram_we    = 1'b1;
               ram_wdata = fpu_result;
               if (is_binary(op_ff)) begin
                  ram_waddr = dm2[AW-1:0];
                  depth_in  = dm1;
               end else begin
                  ram_waddr = dm1[AW-1:0];
               end
               state_in = T_FINISH;
            end
         end
         T_FINISH: begin
            value_in = '0;
            if (!last_ff) begin
               state_in = T_IDLE;
            end else if ((err_ff == rfe_pkg::ERR_NONE) && (depth_ff != DW'(1))) begin
               err_in   = rfe_pkg::ERR_SYNTAX;
               state_in = T_RESP;
            end else if (err_ff == rfe_pkg::ERR_NONE) begin
               ram_raddr = '0;
               state_in  = T_RD_ZERO;
            end else begin
               state_in = T_RESP;
            end
         end
         T_RD_ZERO: begin
            value_in = ram_rdata;
            state_in = T_RESP;
         end
         T_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = value_ff;
               rsp_err_in    = err_ff;
               depth_in      = '0;
               err_in        = rfe_pkg::ERR_NONE;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         depth_ff     <= '0;
         err_ff       <= rfe_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      sec_ff        <= sec_in;
      value_ff      <= value_in;
      rsp_result_ff <= rsp_result_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign req_chan.ready       = (state_ff == T_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_bits = rsp_result_ff;
   assign rsp_chan.error_code  = rsp_err_ff;

   `RFE_ASSERT_IMPL(a_depth_bound, 1'b1, depth_ff <= DW'(STACK_DEPTH))
   `RFE_ASSERT_IMPL(a_fpu_start_free, fpu_req.start, !fpu_rsp.busy)
   `RFE_ASSERT_IMPL(a_fpu_done_waited, fpu_rsp.done, state_ff == T_FPU)
   `RFE_ASSERT_NEXT(a_resp_clears, (state_ff == T_RESP) && (!rsp_valid_ff || rsp_chan.ready),
                    (depth_ff == '0) && (err_ff == rfe_pkg::ERR_NONE) && rsp_valid_ff)

endmodule

`default_nettype wire
